// ----- rtl/core/cyclic_state_canonicalizer_top_macros.svh -----
// Assertion macros shared by the canonicaliser RTL.
// Included by the files that carry concurrent assertions; no other dependencies.
`ifndef CYCLIC_STATE_CANONICALIZER_TOP_MACROS_SVH
`define CYCLIC_STATE_CANONICALIZER_TOP_MACROS_SVH

// Property checked at every clock edge outside reset.
`define CSC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("canonicaliser assertion failed");

// Property checked at every clock edge, reset included.
`define CSC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("canonicaliser assertion failed during reset");

`endif

// ----- rtl/core/csc_pkg.sv -----
// Package of the cyclic state canonicaliser: ring size, widths, codes and shared types.
// No dependencies; imported by the top level, csc_ring, csc_track and the bench.
`timescale 1ns / 1ps
`default_nettype none

package csc_pkg;

  localparam int SITES = 16;
  localparam int CW    = $clog2(SITES + 1);  // step counter, 1 to SITES
  localparam int SW    = $clog2(SITES);      // rotation count, 0 to SITES-1
  localparam int AW    = $clog2(SITES) + 1;  // momentum phase accumulator

  typedef enum logic [1:0] {
    VERDICT_ACCEPT       = 2'd0,
    VERDICT_NOT_SMALLEST = 2'd1,
    VERDICT_INCOMPAT     = 2'd2
  } verdict_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  typedef struct packed {
    logic          load;
    logic          step;
    logic [CW-1:0] cnt;
  } ctrl_t;

  typedef struct packed {
    logic [SITES-1:0] rot;
    logic             match;
  } ring_stat_t;

  typedef struct packed {
    logic [SITES-1:0] best;
    logic [SW-1:0]    shift;
    logic [CW-1:0]    per;
    logic             compat;
  } result_t;

  // Momentum reduced into the ring range by repeated subtraction; a 4-bit k
  // needs at most seven passes for the smallest ring.
  function automatic logic [AW-1:0] kmod(input logic [3:0] k);
    int v;
    v = int'(k);
    for (int i = 0; i < 8; i++) begin
      if (v >= SITES) begin
        v = v - SITES;
      end
    end
    return AW'(v);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/csc_if.sv -----
// Request and response channel interfaces of the canonicaliser.
// Depends on nothing, not even csc_pkg; payload widths are fixed.
`timescale 1ns / 1ps
`default_nettype none

interface csc_req_if;
  logic        valid;
  logic        ready;
  logic [15:0] state_word;
  logic [3:0]  momentum;

  modport source (output valid, state_word, momentum, input ready);
  modport sink   (input valid, state_word, momentum, output ready);
endinterface

interface csc_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] rep_value;
  logic [3:0]  rep_shift;
  logic [4:0]  period;
  logic [1:0]  verdict;

  modport source (output valid, rep_value, rep_shift, period, verdict, input ready);
  modport sink   (input valid, rep_value, rep_shift, period, verdict, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/cyclic_state_canonicalizer_top.sv -----
// Top level of the cyclic state canonicaliser: sequencer, output register, ring and tracker.
// Depends on csc_pkg, csc_if, csc_ring, csc_track and the assertion macro header.
//
//   channel  | direction | payload
//   ---------+-----------+------------------------------------------------
//   req_i    | in        | state_word[15:0], momentum[3:0]
//   rsp_o    | out       | rep_value[15:0], rep_shift[3:0], period[4:0], verdict[1:0]
//
// Each request passes through the load edge, SITES rotation steps through
// the cell ring, and the write of the output register.
// One request is in the ring at a time; the next is taken once the last is
// in the output register, even while that result still waits for rsp ready.
// A stalled response holds the finished request in the ring until it frees.
// Reset clears the sequencer, the output valid flag and the period register only.
`timescale 1ns / 1ps
`default_nettype none
`include "cyclic_state_canonicalizer_top_macros.svh"

module cyclic_state_canonicalizer_top (
  input  wire         clk_i,
  input  wire         rst_ni,
  csc_req_if.sink     req_i,
  csc_rsp_if.source   rsp_o
);
  import csc_pkg::*;

  state_e           state_q, state_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             out_load;
  logic             req_fire;
  ctrl_t            ctrl;
  ring_stat_t       stat;
  result_t          res;
  logic [SITES-1:0] word;
  logic [31:0]      word_ext;
  logic [31:0]      best_ext;
  logic [31:0]      shift_ext;
  logic [31:0]      per_ext;
  verdict_e         verdict_d;
  logic [15:0]      rep_value_q;
  logic [3:0]       rep_shift_q;
  logic [4:0]       period_q;
  verdict_e         verdict_q;

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;

  // Bits of the word above the ring are dropped.
  assign word_ext = 32'(req_i.state_word);
  assign word     = word_ext[SITES-1:0];

  assign ctrl.load = req_fire;
  assign ctrl.step = (state_q == ST_RUN);
  assign ctrl.cnt  = cnt_q;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    out_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          state_d = ST_RUN;
          cnt_d   = CW'(1);
        end
      end
      ST_RUN: begin
        if (cnt_q == CW'(SITES)) begin
          state_d = ST_DONE;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      ST_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  csc_ring u_ring (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .word_i (word),
    .stat_o (stat)
  );

  csc_track u_track (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .word_i     (word),
    .momentum_i (req_i.momentum),
    .stat_i     (stat),
    .res_o      (res)
  );

  // The best value only moves on a strictly smaller rotation, so a nonzero
  // count means the word is not its own representative.
  always_comb begin
    if (res.shift != '0) begin
      verdict_d = VERDICT_NOT_SMALLEST;
    end else if (res.compat) begin
      verdict_d = VERDICT_ACCEPT;
    end else begin
      verdict_d = VERDICT_INCOMPAT;
    end
  end

  assign best_ext  = 32'(res.best);
  assign shift_ext = 32'(res.shift);
  assign per_ext   = 32'(res.per);

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      rep_value_q <= best_ext[15:0];
      rep_shift_q <= shift_ext[3:0];
      period_q    <= per_ext[4:0];
      verdict_q   <= verdict_d;
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.rep_value = rep_value_q;
  assign rsp_o.rep_shift = rep_shift_q;
  assign rsp_o.period    = period_q;
  assign rsp_o.verdict   = verdict_q;

  `CSC_ASSERT(a_fire_starts_run, clk_i, rst_ni, req_fire |=> (state_q == ST_RUN))
  `CSC_ASSERT(a_run_count_range, clk_i, rst_ni,
              (state_q == ST_RUN) |-> ((cnt_q != '0) && (cnt_q <= CW'(SITES))))
  `CSC_ASSERT(a_period_found, clk_i, rst_ni, (state_q == ST_DONE) |-> (res.per != '0))
  `CSC_ASSERT(a_load_from_done, clk_i, rst_ni, out_load |-> (state_q == ST_DONE))
  `CSC_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |=> (state_q == ST_IDLE) && !out_valid_q)

endmodule

`default_nettype wire

// ----- rtl/core/csc_cell.sv -----
// One site of the rotating ring: the current bit and the bit loaded at the start.
// Depends on nothing; instantiated by csc_ring.
`timescale 1ns / 1ps
`default_nettype none

module csc_cell (
  input  wire  clk_i,
  input  wire  load_i,
  input  wire  shift_i,
  input  wire  load_bit_i,
  input  wire  nb_bit_i,
  output logic bit_o,
  output logic match_o
);

  logic bit_q;
  logic orig_q;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bit_q  <= load_bit_i;
      orig_q <= load_bit_i;
    end else if (shift_i) begin
      bit_q <= nb_bit_i;
    end
  end

  // The neighbour's bit is this site's value after the coming rotation.
  assign bit_o   = bit_q;
  assign match_o = (nb_bit_i == orig_q);

endmodule

`default_nettype wire

// ----- rtl/core/csc_ring.sv -----
// Ring of SITES cells that rotates the word by one site per step.
// Depends on csc_pkg and csc_cell.
`timescale 1ns / 1ps
`default_nettype none

module csc_ring (
  input  wire                      clk_i,
  input  csc_pkg::ctrl_t           ctrl_i,
  input  wire  [csc_pkg::SITES-1:0] word_i,
  output csc_pkg::ring_stat_t      stat_o
);
  import csc_pkg::*;

  logic [SITES-1:0] cur;
  logic [SITES-1:0] nb;
  logic [SITES-1:0] match;

  for (genvar i = 0; i < SITES; i++) begin : g_cell
    // Site i takes the bit of site i+1; the top site takes site 0.
    assign nb[i] = cur[(i + 1) % SITES];

    csc_cell u_cell (
      .clk_i      (clk_i),
      .load_i     (ctrl_i.load),
      .shift_i    (ctrl_i.step),
      .load_bit_i (word_i[i]),
      .nb_bit_i   (nb[i]),
      .bit_o      (cur[i]),
      .match_o    (match[i])
    );
  end

  assign stat_o.rot   = nb;
  assign stat_o.match = &match;

endmodule

`default_nettype wire

// ----- rtl/core/csc_track.sv -----
// Tracks the smallest rotation, its count, the period and momentum compatibility.
// Depends on csc_pkg; fed by csc_ring and the sequencer in the top level.
`timescale 1ns / 1ps
`default_nettype none

module csc_track (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  csc_pkg::ctrl_t            ctrl_i,
  input  wire  [csc_pkg::SITES-1:0] word_i,
  input  wire  [3:0]                momentum_i,
  input  csc_pkg::ring_stat_t       stat_i,
  output csc_pkg::result_t          res_o
);
  import csc_pkg::*;

  logic [SITES-1:0] best_q;
  logic [SW-1:0]    shift_q;
  logic [CW-1:0]    per_q, per_d;
  logic [AW-1:0]    acc_q, acc_d;
  logic [AW-1:0]    kred_q;
  logic             compat_q;
  logic [AW-1:0]    acc_sum;

  // acc_d holds k*r modulo SITES for the current step r; the period p is
  // compatible exactly when k*p is a multiple of SITES.
  always_comb begin
    acc_sum = acc_q + kred_q;
    acc_d   = (acc_sum >= AW'(SITES)) ? (acc_sum - AW'(SITES)) : acc_sum;
    per_d   = per_q;
    if (ctrl_i.load) begin
      per_d = '0;
    end else if (ctrl_i.step && (per_q == '0) && stat_i.match) begin
      per_d = ctrl_i.cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      per_q <= '0;
    end else begin
      per_q <= per_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      best_q   <= word_i;
      shift_q  <= '0;
      acc_q    <= '0;
      kred_q   <= kmod(momentum_i);
      compat_q <= 1'b0;
    end else if (ctrl_i.step) begin
      acc_q <= acc_d;
      if ((ctrl_i.cnt < CW'(SITES)) && (stat_i.rot < best_q)) begin
        best_q  <= stat_i.rot;
        shift_q <= ctrl_i.cnt[SW-1:0];
      end
      if ((per_q == '0) && stat_i.match) begin
        compat_q <= (acc_d == '0);
      end
    end
  end

  assign res_o.best   = best_q;
  assign res_o.shift  = shift_q;
  assign res_o.per    = per_q;
  assign res_o.compat = compat_q;

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// Self-checking bench for the cyclic state canonicaliser: directed corner words, then random,
// periodic and self-representative words, with random gaps on both channels. Depends on csc_pkg and csc_if.
`timescale 1ns / 1ps

module tb;
  import csc_pkg::*;

  localparam int LIMIT     = 400000;
  localparam int N_RANDOM  = 1400;
  localparam int N_QUIET   = 200;
  localparam int N_DIRECT  = 24;

  typedef struct packed {
    logic [15:0] rep;
    logic [3:0]  shift;
    logic [4:0]  per;
    verdict_e    verdict;
  } canon_t;

  typedef struct packed {
    logic [15:0] word;
    logic [3:0]  k;
    logic        typed;
    canon_t      want;
  } corner_t;

  // Rows with typed = 1 carry a result that can be read straight off the word;
  // the rest are checked against canonical_form alone.
  localparam corner_t CORNERS [N_DIRECT] = '{
    '{16'h0000, 4'd0,  1'b1, '{16'h0000, 4'd0,  5'd1,  VERDICT_ACCEPT}},
    '{16'h0000, 4'd15, 1'b1, '{16'h0000, 4'd0,  5'd1,  VERDICT_INCOMPAT}},
    '{16'hFFFF, 4'd0,  1'b1, '{16'hFFFF, 4'd0,  5'd1,  VERDICT_ACCEPT}},
    '{16'hFFFF, 4'd15, 1'b1, '{16'hFFFF, 4'd0,  5'd1,  VERDICT_INCOMPAT}},
    '{16'h0001, 4'd0,  1'b1, '{16'h0001, 4'd0,  5'd16, VERDICT_ACCEPT}},
    '{16'h0001, 4'd15, 1'b1, '{16'h0001, 4'd0,  5'd16, VERDICT_ACCEPT}},
    '{16'h8000, 4'd0,  1'b1, '{16'h0001, 4'd15, 5'd16, VERDICT_NOT_SMALLEST}},
    '{16'h8000, 4'd8,  1'b1, '{16'h0001, 4'd15, 5'd16, VERDICT_NOT_SMALLEST}},
    '{16'h5555, 4'd8,  1'b1, '{16'h5555, 4'd0,  5'd2,  VERDICT_ACCEPT}},
    '{16'h5555, 4'd4,  1'b1, '{16'h5555, 4'd0,  5'd2,  VERDICT_INCOMPAT}},
    '{16'hAAAA, 4'd1,  1'b1, '{16'h5555, 4'd1,  5'd2,  VERDICT_NOT_SMALLEST}},
    '{16'h7FFF, 4'd0,  1'b1, '{16'h7FFF, 4'd0,  5'd16, VERDICT_ACCEPT}},
    '{16'hFFFE, 4'd3,  1'b1, '{16'h7FFF, 4'd1,  5'd16, VERDICT_NOT_SMALLEST}},
    '{16'h0F0F, 4'd1,  1'b0, '0},
    '{16'h0F0F, 4'd2,  1'b0, '0},
    '{16'h1111, 4'd4,  1'b0, '0},
    '{16'h1111, 4'd2,  1'b0, '0},
    '{16'h3333, 4'd6,  1'b0, '0},
    '{16'h0303, 4'd12, 1'b0, '0},
    '{16'h00FF, 4'd0,  1'b0, '0},
    '{16'h0101, 4'd8,  1'b0, '0},
    '{16'h0101, 4'd3,  1'b0, '0},
    '{16'hC000, 4'd0,  1'b0, '0},
    '{16'h1234, 4'd7,  1'b0, '0}
  };

  logic clk_i;
  logic rst_ni;
  logic quiet;
  int   mismatches;
  int   cycles;
  int   stall_left;

  canon_t pending_reps [$];

  csc_req_if req ();
  csc_rsp_if rsp ();

  cyclic_state_canonicalizer_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Smallest rotation, its first shift, the period and the momentum verdict of one word.
  function automatic canon_t canonical_form(input logic [15:0] word, input logic [3:0] k);
    logic [31:0] mask;
    logic [31:0] ring;
    logic [31:0] cur;
    logic [31:0] best;
    int          best_shift;
    int          per;
    canon_t      res;
    mask = (SITES >= 32) ? 32'hFFFF_FFFF : ((32'd1 << SITES) - 32'd1);
    ring = {16'd0, word} & mask;
    cur  = ring;
    best = ring;
    best_shift = 0;
    per  = 0;
    for (int r = 1; r <= SITES; r++) begin
      cur = ((cur >> 1) | ((cur & 32'd1) << (SITES - 1))) & mask;
      if (r < SITES && cur < best) begin
        best = cur;
        best_shift = r;
      end
      if (per == 0 && cur == ring) begin
        per = r;
      end
    end
    res.rep   = best[15:0];
    res.shift = best_shift[3:0];
    res.per   = per[4:0];
    if (best < ring) begin
      res.verdict = VERDICT_NOT_SMALLEST;
    end else if ((int'(k) % (SITES / per)) != 0) begin
      res.verdict = VERDICT_INCOMPAT;
    end else begin
      res.verdict = VERDICT_ACCEPT;
    end
    return res;
  endfunction

  // Offers one request, with an occasional idle burst ahead of it, and records the
  // expected result once the request has been taken.
  task automatic offer(input logic [15:0] word, input logic [3:0] k, input logic typed,
                       input canon_t want);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    req.valid      <= 1'b1;
    req.state_word <= word;
    req.momentum   <= k;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    pending_reps = {pending_reps, (typed ? want : canonical_form(word, k))};
  endtask

  // Word built from a short pattern repeated round the ring, so short periods turn up often.
  function automatic logic [15:0] periodic_word();
    int          p;
    logic [31:0] pat;
    logic [31:0] w;
    p = $urandom_range(1, SITES);
    while (SITES % p != 0) p = $urandom_range(1, SITES);
    pat = (p >= 32) ? $urandom() : ($urandom() & ((32'd1 << p) - 32'd1));
    w = '0;
    for (int i = 0; i < SITES / p; i++) begin
      w = w | (pat << (i * p));
    end
    return w[15:0];
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni !== 1'b1) begin
      rsp.ready  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      rsp.ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 11) == 0) begin
      rsp.ready  <= 1'b0;
      stall_left <= $urandom_range(0, 17);
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    canon_t want;
    if (rst_ni && rsp.valid && rsp.ready) begin
      if (pending_reps.size() == 0) begin
        $display("%0t: result with nothing outstanding: rep %h shift %0d period %0d verdict %0d",
                 $time, rsp.rep_value, rsp.rep_shift, rsp.period, rsp.verdict);
        mismatches++;
      end else begin
        want = pending_reps.pop_front();
        if (rsp.rep_value !== want.rep) begin
          $display("%0t: rep_value expected %h, got %h", $time, want.rep, rsp.rep_value);
          mismatches++;
        end
        if (rsp.rep_shift !== want.shift) begin
          $display("%0t: rep_shift expected %0d, got %0d", $time, want.shift, rsp.rep_shift);
          mismatches++;
        end
        if (rsp.period !== want.per) begin
          $display("%0t: period expected %0d, got %0d", $time, want.per, rsp.period);
          mismatches++;
        end
        if (rsp.verdict !== want.verdict) begin
          $display("%0t: verdict expected %0d, got %0d", $time, want.verdict, rsp.verdict);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin
    logic [15:0] word;
    logic [3:0]  k;
    canon_t      form;
    rst_ni         <= 1'b0;
    quiet          <= 1'b0;
    req.valid      <= 1'b0;
    req.state_word <= '0;
    req.momentum   <= '0;
    mismatches     = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < N_DIRECT; i++) begin
      offer(CORNERS[i].word, CORNERS[i].k, CORNERS[i].typed, CORNERS[i].want);
    end

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM - N_QUIET) begin
        quiet <= 1'b1;
      end
      k = 4'($urandom_range(0, 15));
      case ($urandom_range(0, 2))
        0: word = 16'($urandom());
        1: word = periodic_word();
        default: begin
          // Replace the word by its own representative so the momentum test decides.
          form = canonical_form(16'($urandom()), k);
          word = form.rep;
        end
      endcase
      offer(word, k, 1'b0, '0);
    end
    req.valid <= 1'b0;

    while (pending_reps.size() != 0) @(posedge clk_i);
    repeat (SITES + 4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/csc_pkg.sv
rtl/core/csc_if.sv
rtl/core/csc_cell.sv
rtl/core/csc_ring.sv
rtl/core/csc_track.sv
rtl/core/cyclic_state_canonicalizer_top.sv
sim/tb.sv
